@@ hw/rtl/grsr_pkg.sv @@
// shared types and constants for the glyph row span rasterizer
package grsr_pkg;

  // default glyph row width and run queue depth
  localparam int MASK_BITS_DEFAULT   = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // fixed field widths
  localparam int COORD_W  = 10;
  localparam int SCALE_W  = 8;
  localparam int COLOR_W  = 16;
  localparam int HEIGHT_W = 8;

  // configuration register indices
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'b1;

  // register reset values
  localparam logic [COORD_W-1:0] WINDOW_WIDTH_RESET  = 10'd320;
  localparam logic [COORD_W-1:0] WINDOW_HEIGHT_RESET = 10'd240;

  // colour inversion applied to every span
  localparam logic [COLOR_W-1:0] COLOR_INVERT = 16'hFFFF;

  // per-row values that travel with every run
  typedef struct packed {
    logic [COORD_W-1:0] row_x;
    logic [COORD_W-1:0] row_y;
    logic [SCALE_W-1:0] scale;
    logic [COLOR_W-1:0] pixel_value;
  } item_t;

  // clipping window
  typedef struct packed {
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } window_t;

endpackage

@@ hw/rtl/grsr_front.sv @@
// front end: takes rows, splits masks into runs, one a cycle unless queue full
module grsr_front #(
  parameter int MASK_BITS = grsr_pkg::MASK_BITS_DEFAULT,
  localparam int IDX_W = $clog2(MASK_BITS),
  localparam int LEN_W = $clog2(MASK_BITS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [MASK_BITS-1:0] mask_byte,
  input  grsr_pkg::item_t      in_item,
  input  logic                 full,
  output logic                 push,
  output grsr_pkg::item_t      push_item,
  output logic [IDX_W-1:0]     push_start,
  output logic [LEN_W-1:0]     push_len,
  output logic [IDX_W-1:0]     push_next,
  output logic                 push_has_next
);
  import grsr_pkg::*;

  // remaining mask, bit 0 is the leftmost pixel
  logic [MASK_BITS-1:0] bits;
  item_t                item;

  logic [MASK_BITS-1:0] mask_rev;
  logic [MASK_BITS-1:0] first_oh;
  logic [MASK_BITS-1:0] rest;
  logic [MASK_BITS-1:0] next_oh;
  logic [MASK_BITS:0]   sum;
  logic [MASK_BITS:0]   end_oh;
  logic [IDX_W-1:0]     first_idx;
  logic [IDX_W-1:0]     next_idx;
  logic [LEN_W-1:0]     end_idx;
  logic                 active;
  logic                 adv;
  logic                 load;

  // leftmost run: isolate its first bit, carry through it to find its end
  always_comb begin
    for (int b = 0; b < MASK_BITS; b++) begin
      mask_rev[b] = mask_byte[MASK_BITS-1-b];
    end
    first_oh = bits & (~bits + 1'b1);
    sum      = {1'b0, bits} + {1'b0, first_oh};
    rest     = bits & sum[MASK_BITS-1:0];
    end_oh   = sum & ~{1'b0, bits};
    next_oh  = rest & (~rest + 1'b1);
    first_idx = '0;
    next_idx  = '0;
    end_idx   = '0;
    for (int b = 0; b < MASK_BITS; b++) begin
      if (first_oh[b]) first_idx = first_idx | IDX_W'(b);
      if (next_oh[b])  next_idx  = next_idx | IDX_W'(b);
    end
    for (int b = 0; b <= MASK_BITS; b++) begin
      if (end_oh[b]) end_idx = end_idx | LEN_W'(b);
    end
  end

  // handshake: a new row loads as the last run of the current one leaves
  always_comb begin
    active = |bits;
    adv    = active && !full;
    busy   = active && !(adv && (rest == '0));
    load   = start && !busy;
  end

  // run out to the queue
  always_comb begin
    push          = adv;
    push_item     = item;
    push_start    = first_idx;
    push_len      = end_idx - LEN_W'(first_idx);
    push_next     = next_idx;
    push_has_next = |rest;
  end

  // remaining mask
  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
    end else if (load) begin
      bits <= mask_rev;
    end else if (adv) begin
      bits <= rest;
    end
  end

  // row values held while its runs leave
  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

@@ hw/rtl/grsr_queue.sv @@
// short run queue between front and back end
module grsr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = grsr_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W:0]   wr_ptr;
  logic [PTR_W:0]   rd_ptr;

  // flags from pointer wrap bits
  always_comb begin
    empty    = (wr_ptr == rd_ptr);
    full     = (wr_ptr[PTR_W] != rd_ptr[PTR_W]) &&
               (wr_ptr[PTR_W-1:0] == rd_ptr[PTR_W-1:0]);
    pop_data = mem[rd_ptr[PTR_W-1:0]];
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[PTR_W-1:0]] <= push_data;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
    end
  end

endmodule

@@ hw/rtl/grsr_back.sv @@
// back end: scales each run, clips it to the window and drives the span strobe
module grsr_back #(
  parameter int MASK_BITS = grsr_pkg::MASK_BITS_DEFAULT,
  localparam int IDX_W = $clog2(MASK_BITS),
  localparam int LEN_W = $clog2(MASK_BITS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  grsr_pkg::window_t               window,
  input  logic                            run_valid,
  input  grsr_pkg::item_t                 run_item,
  input  logic [IDX_W-1:0]                run_start,
  input  logic [LEN_W-1:0]                run_len,
  input  logic [IDX_W-1:0]                run_next,
  input  logic                            run_has_next,
  output logic                            span_valid,
  output logic [grsr_pkg::COORD_W-1:0]    span_x,
  output logic [grsr_pkg::COORD_W-1:0]    span_y,
  output logic [grsr_pkg::COORD_W-1:0]    span_width,
  output logic [grsr_pkg::HEIGHT_W-1:0]   span_height,
  output logic [grsr_pkg::COLOR_W-1:0]    pixel_value,
  output logic                            last
);
  import grsr_pkg::*;

  localparam int POS_PW = SCALE_W + IDX_W;
  localparam int LEN_PW = SCALE_W + LEN_W;
  localparam int XW     = SCALE_W + LEN_W + 1;

  // product stage
  logic              s1_valid;
  item_t             s1_item;
  logic [POS_PW-1:0] s1_first_prod;
  logic [LEN_PW-1:0] s1_width_prod;
  logic [POS_PW-1:0] s1_next_prod;
  logic              s1_has_next;

  // clip stage
  logic [XW-1:0]       x_left;
  logic [XW-1:0]       x_next;
  logic                x_in;
  logic                y_in;
  logic                keep;
  logic                keep_next;
  logic [COORD_W-1:0]  avail_w;
  logic [COORD_W-1:0]  avail_h;
  logic [COORD_W-1:0]  w_clip;
  logic [HEIGHT_W-1:0] h_clip;

  // scale the run position, length and the next run position
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= run_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_item       <= run_item;
    s1_first_prod <= POS_PW'(run_item.scale) * POS_PW'(run_start);
    s1_width_prod <= LEN_PW'(run_item.scale) * LEN_PW'(run_len);
    s1_next_prod  <= POS_PW'(run_item.scale) * POS_PW'(run_next);
    s1_has_next   <= run_has_next;
  end

  // clip; survival falls off left to right, so the next run decides last
  always_comb begin
    x_left    = XW'(s1_item.row_x) + XW'(s1_first_prod);
    x_next    = XW'(s1_item.row_x) + XW'(s1_next_prod);
    x_in      = x_left < XW'(window.width);
    y_in      = s1_item.row_y < window.height;
    keep      = s1_valid && (s1_item.scale != '0) && x_in && y_in;
    keep_next = s1_has_next && (x_next < XW'(window.width));
    avail_w   = window.width - x_left[COORD_W-1:0];
    avail_h   = window.height - s1_item.row_y;
    w_clip    = (XW'(s1_width_prod) > XW'(avail_w)) ? avail_w
                                                     : s1_width_prod[COORD_W-1:0];
    h_clip    = (COORD_W'(s1_item.scale) > avail_h) ? avail_h[HEIGHT_W-1:0]
                                                     : s1_item.scale;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else begin
      span_valid <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      span_x      <= x_left[COORD_W-1:0];
      span_y      <= s1_item.row_y;
      span_width  <= w_clip;
      span_height <= h_clip;
      pixel_value <= s1_item.pixel_value;
      last        <= !keep_next;
    end
  end

endmodule

@@ hw/rtl/glyph_row_span_rasterizer_core.sv @@
// top level of the glyph row span rasterizer
// path: a row passes the front-end mask register, a queue entry, the product
//   stage and the output register; the run extractor in the front end splits it
//   into at most (MASK_BITS+1)/2 runs of set bits and stalls on a full queue
// spans leave one per cycle and the receiver cannot stall them
// reset: synchronous, clears the run queue and pipeline, window returns to 320x240
module glyph_row_span_rasterizer_core #(
  parameter int MASK_BITS   = grsr_pkg::MASK_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = grsr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [MASK_BITS-1:0]            mask_byte,
  input  logic [grsr_pkg::COORD_W-1:0]    row_x,
  input  logic [grsr_pkg::COORD_W-1:0]    row_y,
  input  logic [grsr_pkg::SCALE_W-1:0]    scale,
  input  logic [grsr_pkg::COLOR_W-1:0]    color,
  input  logic                            cfg_write,
  input  logic [grsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [grsr_pkg::COORD_W-1:0]    cfg_data,
  output logic                            span_valid,
  output logic [grsr_pkg::COORD_W-1:0]    span_x,
  output logic [grsr_pkg::COORD_W-1:0]    span_y,
  output logic [grsr_pkg::COORD_W-1:0]    span_width,
  output logic [grsr_pkg::HEIGHT_W-1:0]   span_height,
  output logic [grsr_pkg::COLOR_W-1:0]    pixel_value,
  output logic                            last
);
  import grsr_pkg::*;

  localparam int IDX_W   = $clog2(MASK_BITS);
  localparam int LEN_W   = $clog2(MASK_BITS + 1);
  localparam int ENTRY_W = $bits(item_t) + IDX_W + LEN_W + IDX_W + 1;

  window_t            window;
  item_t              in_item;
  logic               q_full;
  logic               q_empty;
  logic               push;
  item_t              push_item;
  logic [IDX_W-1:0]   push_start;
  logic [LEN_W-1:0]   push_len;
  logic [IDX_W-1:0]   push_next;
  logic               push_has_next;
  logic [ENTRY_W-1:0] push_data;
  logic [ENTRY_W-1:0] pop_data;
  item_t              run_item;
  logic [IDX_W-1:0]   run_start;
  logic [LEN_W-1:0]   run_len;
  logic [IDX_W-1:0]   run_next;
  logic               run_has_next;

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window.width  <= WINDOW_WIDTH_RESET;
      window.height <= WINDOW_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_WIDTH:  window.width  <= cfg_data;
        REG_WINDOW_HEIGHT: window.height <= cfg_data;
        default: ;
      endcase
    end
  end

  // row values, colour inverted on the way in
  always_comb begin
    in_item.row_x       = row_x;
    in_item.row_y       = row_y;
    in_item.scale       = scale;
    in_item.pixel_value = color ^ COLOR_INVERT;
  end

  grsr_front #(
    .MASK_BITS (MASK_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mask_byte     (mask_byte),
    .in_item       (in_item),
    .full          (q_full),
    .push          (push),
    .push_item     (push_item),
    .push_start    (push_start),
    .push_len      (push_len),
    .push_next     (push_next),
    .push_has_next (push_has_next)
  );

  // pack and unpack queue entries
  assign push_data = {push_item, push_start, push_len, push_next, push_has_next};
  assign {run_item, run_start, run_len, run_next, run_has_next} = pop_data;

  grsr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (!q_empty),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  grsr_back #(
    .MASK_BITS (MASK_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .window       (window),
    .run_valid    (!q_empty),
    .run_item     (run_item),
    .run_start    (run_start),
    .run_len      (run_len),
    .run_next     (run_next),
    .run_has_next (run_has_next),
    .span_valid   (span_valid),
    .span_x       (span_x),
    .span_y       (span_y),
    .span_width   (span_width),
    .span_height  (span_height),
    .pixel_value  (pixel_value),
    .last         (last)
  );

endmodule

@@ hw/rtl/grsr_checker.sv @@
// port-level assertions for the span rasterizer, bound to the top level
module grsr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          span_valid,
  input logic                          last,
  input logic [grsr_pkg::COORD_W-1:0]  span_x,
  input logic [grsr_pkg::COORD_W-1:0]  span_y,
  input logic [grsr_pkg::COORD_W-1:0]  span_width,
  input logic [grsr_pkg::HEIGHT_W-1:0] span_height
);

  // spans of zero size never leave
  a_nonzero_size: assert property (@(posedge clk)
    span_valid |-> (span_width != '0) && (span_height != '0))
    else $error("span of zero size transferred");

  // nothing leaves straight out of reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !span_valid)
    else $error("span strobe right after reset");

  // spans of one row leave back to back
  a_row_contiguous: assert property (@(posedge clk) disable iff (rst)
    span_valid && !last |=> span_valid)
    else $error("gap inside the spans of one row");

  // spans of one row move right on the same y
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    span_valid && !last |=> (span_x > $past(span_x)) && (span_y == $past(span_y)))
    else $error("spans of one row out of order");

endmodule

bind glyph_row_span_rasterizer_core grsr_checker u_grsr_checker (
  .clk         (clk),
  .rst         (rst),
  .span_valid  (span_valid),
  .last        (last),
  .span_x      (span_x),
  .span_y      (span_y),
  .span_width  (span_width),
  .span_height (span_height)
);
